// ----- src/vna_pkg.sv -----
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types, widths and state codes for the vertex normal accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

  localparam int IDX_W   = 10;  // vertex index
  localparam int COORD_W = 24;  // Q11.12 coordinate, Q9.14 accumulator
  localparam int EDGE_W  = 25;  // difference of two coordinates
  localparam int Q14_W   = 16;  // unit component, Q1.14
  localparam int NRM_W   = 19;  // face normal component after rounding
  localparam int LEN_W   = 62;  // squared length after normalizing shift
  localparam int ROOT_W  = 31;  // integer square root of LEN_W bits
  localparam int NUM_W   = 46;  // scaled dividend
  localparam int QUO_W   = 15;  // quotient magnitude, at most 2^14

  typedef logic [IDX_W-1:0]          vidx_t;
  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [EDGE_W-1:0]  edge_t;
  typedef logic signed [Q14_W-1:0]   q14_t;

  localparam q14_t Q14_ONE = 16'sd16384;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_WRITE = 2'd1,
    OP_FACE  = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef struct packed {
    edge_t x;
    edge_t y;
    edge_t z;
  } vec_t;

  typedef struct packed {
    logic defined;
    q14_t x;
    q14_t y;
    q14_t z;
  } unit_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_N1,
    ST_N2,
    ST_CROSS,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_RD_WAIT,
    ST_RD_NORM,
    ST_OUT
  } top_state_t;

  typedef enum logic [2:0] {
    NS_IDLE,
    NS_SQ,
    NS_SHIFT,
    NS_SQRT,
    NS_DLOAD,
    NS_DIV,
    NS_DONE
  } norm_state_t;

endpackage

// ----- src/vna_if.sv -----
// ----------------------------------------------------------------------------
// vna_in_if / vna_out_if
// Valid/ready channels for commands and for read results.
// ----------------------------------------------------------------------------
interface vna_in_if;
  import vna_pkg::*;

  logic   valid;
  logic   ready;
  logic [1:0] operation;
  vidx_t  vertex_a;
  vidx_t  vertex_b;
  vidx_t  vertex_c;
  coord_t coord_x;
  coord_t coord_y;
  coord_t coord_z;

  modport source (
    output valid, operation, vertex_a, vertex_b, vertex_c, coord_x, coord_y, coord_z,
    input  ready
  );
  modport sink (
    input  valid, operation, vertex_a, vertex_b, vertex_c, coord_x, coord_y, coord_z,
    output ready
  );
endinterface

interface vna_out_if;
  import vna_pkg::*;

  logic valid;
  logic ready;
  q14_t normal_x;
  q14_t normal_y;
  q14_t normal_z;
  logic normal_defined;

  modport source (
    output valid, normal_x, normal_y, normal_z, normal_defined,
    input  ready
  );
  modport sink (
    input  valid, normal_x, normal_y, normal_z, normal_defined,
    output ready
  );
endinterface

// ----- src/vna_norm.sv -----
// ----------------------------------------------------------------------------
// vna_norm
// Scales a three-component vector to unit length in Q1.14: squared length,
// normalizing shift, bit-serial square root, bit-serial division.
// ----------------------------------------------------------------------------
module vna_norm (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  vna_pkg::vec_t  vec,
  output logic           done,
  output vna_pkg::unit_t res
);
  import vna_pkg::*;

  norm_state_t state_r, state_nxt;

  logic [COORD_W-1:0]   mag_r [3];
  logic [2:0]           neg_r;
  logic [1:0]           cnt_r;
  logic [COORD_W-1:0]   mag_sel;
  logic [2*COORD_W-1:0] sq_r, sq_nxt;
  logic [LEN_W-1:0]     len_r, xr_r, root_r, bit_r, trial;
  logic [5:0]           k_r;
  logic [5:0]           shamt;
  logic [NUM_W-1:0]     rem_r, num;
  logic [NUM_W-2:0]     dvs_r;
  logic [QUO_W-1:0]     quo_r, quo_nxt;
  logic [3:0]           step_r;
  logic                 take;
  q14_t                 q_pos;
  q14_t                 u_r [3];
  logic                 def_r;

  function automatic logic [COORD_W-1:0] mag_of(input edge_t v);
    edge_t a;
    a = v[EDGE_W-1] ? -v : v;
    return a[COORD_W-1:0];
  endfunction

  assign mag_sel = (cnt_r == 2'd3) ? '0 : mag_r[cnt_r];
  assign sq_nxt  = mag_sel * mag_sel;
  assign trial   = root_r + bit_r;
  assign shamt   = 6'd14 + {1'b0, k_r[5:1]};
  assign num     = (NUM_W'(mag_sel) << shamt) + NUM_W'(root_r[ROOT_W-1:1]);
  assign take    = (rem_r >= {1'b0, dvs_r});
  assign quo_nxt = {quo_r[QUO_W-2:0], take};
  assign q_pos   = q14_t'({1'b0, quo_nxt});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= NS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      NS_IDLE, NS_DONE: begin
        state_nxt = start ? NS_SQ : NS_IDLE;
      end
      NS_SQ: begin
        if (cnt_r == 2'd3) state_nxt = NS_SHIFT;
      end
      NS_SHIFT: begin
        if (len_r == '0) state_nxt = NS_DONE;
        else if (len_r[LEN_W-1:LEN_W-2] != 2'b00) state_nxt = NS_SQRT;
      end
      NS_SQRT: begin
        if (bit_r[0]) state_nxt = NS_DLOAD;
      end
      NS_DLOAD: state_nxt = NS_DIV;
      NS_DIV: begin
        if (step_r == 4'(QUO_W - 1)) state_nxt = (cnt_r == 2'd2) ? NS_DONE : NS_DLOAD;
      end
      default: state_nxt = NS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      NS_IDLE, NS_DONE: begin
        if (start) begin
          mag_r[0] <= mag_of(vec.x);
          mag_r[1] <= mag_of(vec.y);
          mag_r[2] <= mag_of(vec.z);
          neg_r    <= {vec.z[EDGE_W-1], vec.y[EDGE_W-1], vec.x[EDGE_W-1]};
          cnt_r    <= '0;
          len_r    <= '0;
          k_r      <= '0;
          def_r    <= 1'b0;
        end
      end
      NS_SQ: begin
        sq_r  <= sq_nxt;
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r != 2'd0) len_r <= len_r + LEN_W'(sq_r);
      end
      NS_SHIFT: begin
        if (len_r == '0) begin
          u_r[0] <= '0;
          u_r[1] <= '0;
          u_r[2] <= '0;
        end else if (len_r[LEN_W-1:LEN_W-10] == '0) begin
          // still below 2^52: a shift by 8 cannot overshoot 2^60
          len_r <= len_r << 8;
          k_r   <= k_r + 6'd8;
        end else if (len_r[LEN_W-1:LEN_W-2] == 2'b00) begin
          len_r <= len_r << 2;
          k_r   <= k_r + 6'd2;
        end else begin
          xr_r   <= len_r;
          root_r <= '0;
          bit_r  <= LEN_W'(1) << (LEN_W - 2);
          def_r  <= 1'b1;
        end
      end
      NS_SQRT: begin
        if (xr_r >= trial) begin
          xr_r   <= xr_r - trial;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
        cnt_r <= '0;
      end
      NS_DLOAD: begin
        rem_r  <= num;
        dvs_r  <= {root_r[ROOT_W-1:0], 14'b0};
        quo_r  <= '0;
        step_r <= '0;
      end
      NS_DIV: begin
        if (take) rem_r <= rem_r - {1'b0, dvs_r};
        dvs_r  <= dvs_r >> 1;
        quo_r  <= quo_nxt;
        step_r <= step_r + 4'd1;
        if (step_r == 4'(QUO_W - 1)) begin
          u_r[cnt_r] <= neg_r[cnt_r] ? -q_pos : q_pos;
          cnt_r      <= cnt_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign done = (state_r == NS_DONE);

  always_comb begin
    res.defined = def_r;
    res.x       = u_r[0];
    res.y       = u_r[1];
    res.z       = u_r[2];
  end

  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (done && !res.defined) |-> (res.x == '0 && res.y == '0 && res.z == '0))
    else $error("undefined result not zero");

  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> (res.x <= Q14_ONE && res.x >= -Q14_ONE && res.y <= Q14_ONE &&
              res.y >= -Q14_ONE && res.z <= Q14_ONE && res.z >= -Q14_ONE))
    else $error("unit component out of range");

  a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == NS_DLOAD && cnt_r == 2'd0) |->
      (root_r[LEN_W-1:ROOT_W] == '0 && root_r[ROOT_W-1]))
    else $error("square root outside [2^30, 2^31)");

endmodule

// ----- src/vertex_normal_accumulator_unit.sv -----
// Throughput: one item at a time; the shared unit-length unit (31-step square
//   root, then 15-step division per component) sets read and face time.
// Reset: control clears and the accumulator store is swept to zero before the
//   first command is taken.
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_unit
// Vertex coordinate store and per-vertex face normal accumulator, both in
// synchronous memories; the accumulator is updated by read-modify-write.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator_unit #(
  parameter int VERTEX_COUNT = 1024
) (
  input logic      clk,
  input logic      rst_n,
  vna_in_if.sink   in_ch,
  vna_out_if.source out_ch
);
  import vna_pkg::*;

  localparam int AW = $clog2(VERTEX_COUNT);
  localparam int MW = 3 * COORD_W;
  localparam logic [AW-1:0] CLR_LAST = AW'(VERTEX_COUNT - 1);

  top_state_t state_r, state_nxt;

  logic [MW-1:0] vert_mem [VERTEX_COUNT];
  logic [MW-1:0] acc_mem  [VERTEX_COUNT];
  logic [MW-1:0] vert_rd_r, acc_rd_r;

  logic          in_fire, a_ok, b_ok, c_ok;
  logic          vert_we, vert_re, acc_we, acc_re;
  logic [AW-1:0] vert_raddr, acc_raddr, acc_waddr;
  logic [MW-1:0] acc_wdata, sum_word;

  logic [2:0]    cnt_r;
  logic [AW-1:0] clr_r;
  vidx_t         idx_r [3];
  vidx_t         corner;
  logic [MW-1:0] vtx_r [3];
  unit_t         u1_r, u2_r;
  q14_t          pa, pb;
  logic signed [31:0] prod_r;
  logic signed [32:0] crs_r [3];
  logic signed [NRM_W-1:0] nrm [3];
  unit_t         res_r, out_res_r;
  logic          out_valid_r;

  logic          norm_start, norm_done;
  vec_t          norm_vec, edge1, edge2, acc_vec;
  unit_t         norm_res;

  function automatic edge_t sx(input logic [COORD_W-1:0] v);
    return edge_t'(coord_t'(v));
  endfunction

  function automatic logic [COORD_W-1:0] sat_add(input logic [COORD_W-1:0] acc,
                                                 input logic signed [NRM_W-1:0] n);
    logic signed [COORD_W:0] s;
    s = (COORD_W+1)'(coord_t'(acc)) + (COORD_W+1)'(n);
    if (s > (COORD_W+1)'(2**(COORD_W-1) - 1)) return {1'b0, {(COORD_W-1){1'b1}}};
    if (s < -(COORD_W+1)'(2**(COORD_W-1)))    return {1'b1, {(COORD_W-1){1'b0}}};
    return s[COORD_W-1:0];
  endfunction

  assign in_fire = in_ch.valid & in_ch.ready;
  assign a_ok    = (32'(in_ch.vertex_a) < VERTEX_COUNT);
  assign b_ok    = (32'(in_ch.vertex_b) < VERTEX_COUNT);
  assign c_ok    = (32'(in_ch.vertex_c) < VERTEX_COUNT);

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    corner = idx_r[0];
      2'd1:    corner = idx_r[1];
      default: corner = idx_r[2];
    endcase
  end

  // edges b-a and c-a; accumulator as a vector
  always_comb begin
    edge1.x   = sx(vtx_r[1][COORD_W-1:0])           - sx(vtx_r[0][COORD_W-1:0]);
    edge1.y   = sx(vtx_r[1][2*COORD_W-1:COORD_W])   - sx(vtx_r[0][2*COORD_W-1:COORD_W]);
    edge1.z   = sx(vtx_r[1][MW-1:2*COORD_W])        - sx(vtx_r[0][MW-1:2*COORD_W]);
    edge2.x   = sx(vtx_r[2][COORD_W-1:0])           - sx(vtx_r[0][COORD_W-1:0]);
    edge2.y   = sx(vtx_r[2][2*COORD_W-1:COORD_W])   - sx(vtx_r[0][2*COORD_W-1:COORD_W]);
    edge2.z   = sx(vtx_r[2][MW-1:2*COORD_W])        - sx(vtx_r[0][MW-1:2*COORD_W]);
    acc_vec.x = sx(acc_rd_r[COORD_W-1:0]);
    acc_vec.y = sx(acc_rd_r[2*COORD_W-1:COORD_W]);
    acc_vec.z = sx(acc_rd_r[MW-1:2*COORD_W]);
  end

  // cross product term pairs: y*z'-z*y', z*x'-x*z', x*y'-y*x'
  always_comb begin
    case (cnt_r)
      3'd0:    begin pa = u1_r.y; pb = u2_r.z; end
      3'd1:    begin pa = u1_r.z; pb = u2_r.y; end
      3'd2:    begin pa = u1_r.z; pb = u2_r.x; end
      3'd3:    begin pa = u1_r.x; pb = u2_r.z; end
      3'd4:    begin pa = u1_r.x; pb = u2_r.y; end
      default: begin pa = u1_r.y; pb = u2_r.x; end
    endcase
  end

  // round Q2.28 to Q1.14, halves toward plus infinity
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nrm[i] = NRM_W'((crs_r[i] + 33'sd8192) >>> 14);
    end
    sum_word = {sat_add(acc_rd_r[MW-1:2*COORD_W], nrm[2]),
                sat_add(acc_rd_r[2*COORD_W-1:COORD_W], nrm[1]),
                sat_add(acc_rd_r[COORD_W-1:0], nrm[0])};
  end

  assign vert_we    = in_fire && (op_t'(in_ch.operation) == OP_WRITE) && a_ok;
  assign vert_raddr = AW'(corner);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_ch.ready = 1'b0;
    vert_re     = 1'b0;
    acc_re      = 1'b0;
    acc_we      = 1'b0;
    norm_start  = 1'b0;
    norm_vec    = edge1;
    acc_raddr   = AW'(corner);
    acc_waddr   = AW'(corner);
    acc_wdata   = sum_word;
    case (state_r)
      ST_CLEAR: begin
        acc_we    = 1'b1;
        acc_waddr = clr_r;
        acc_wdata = '0;
        if (clr_r == CLR_LAST) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        acc_raddr   = AW'(in_ch.vertex_a);
        if (in_fire) begin
          case (op_t'(in_ch.operation))
            OP_CLEAR: state_nxt = ST_CLEAR;
            OP_FACE: begin
              if (a_ok && b_ok && c_ok) state_nxt = ST_FETCH;
            end
            OP_READ: begin
              if (a_ok) begin
                acc_re    = 1'b1;
                state_nxt = ST_RD_WAIT;
              end else begin
                state_nxt = ST_OUT;
              end
            end
            default: state_nxt = ST_IDLE;  // vertex write goes straight to the store
          endcase
        end
      end
      ST_FETCH: begin
        vert_re = (cnt_r != 3'd3);
        if (cnt_r == 3'd3) begin
          norm_start = 1'b1;
          state_nxt  = ST_N1;
        end
      end
      ST_N1: begin
        norm_vec = edge2;
        if (norm_done) begin
          if (norm_res.defined) begin
            norm_start = 1'b1;
            state_nxt  = ST_N2;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_N2: begin
        if (norm_done) state_nxt = norm_res.defined ? ST_CROSS : ST_IDLE;
      end
      ST_CROSS: begin
        if (cnt_r == 3'd6) state_nxt = ST_ACC_RD;
      end
      ST_ACC_RD: begin
        acc_re    = 1'b1;
        state_nxt = ST_ACC_WR;
      end
      ST_ACC_WR: begin
        acc_we    = 1'b1;
        state_nxt = (cnt_r == 3'd2) ? ST_IDLE : ST_ACC_RD;
      end
      ST_RD_WAIT: begin
        norm_vec   = acc_vec;
        norm_start = 1'b1;
        state_nxt  = ST_RD_NORM;
      end
      ST_RD_NORM: begin
        if (norm_done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (vert_we) vert_mem[AW'(in_ch.vertex_a)] <= {in_ch.coord_z, in_ch.coord_y, in_ch.coord_x};
    if (vert_re) vert_rd_r <= vert_mem[vert_raddr];
  end

  always_ff @(posedge clk) begin
    if (acc_we) acc_mem[acc_waddr] <= acc_wdata;
    if (acc_re) acc_rd_r <= acc_mem[acc_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        ST_CLEAR: clr_r <= clr_r + AW'(1);
        ST_IDLE: begin
          clr_r <= '0;
          cnt_r <= '0;
          if (in_fire) begin
            idx_r[0] <= in_ch.vertex_a;
            idx_r[1] <= in_ch.vertex_b;
            idx_r[2] <= in_ch.vertex_c;
            if (op_t'(in_ch.operation) == OP_READ && !a_ok) res_r <= '0;
          end
        end
        ST_FETCH: begin
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r != 3'd0) vtx_r[cnt_r[1:0] - 2'd1] <= vert_rd_r;
        end
        ST_N1: begin
          if (norm_done) u1_r <= norm_res;
        end
        ST_N2: begin
          cnt_r <= '0;
          if (norm_done) u2_r <= norm_res;
        end
        ST_CROSS: begin
          prod_r <= pa * pb;
          cnt_r  <= (cnt_r == 3'd6) ? 3'd0 : cnt_r + 3'd1;
          if (cnt_r != 3'd0) begin
            // even term loads, odd term subtracts
            if (cnt_r[0]) crs_r[2'((cnt_r - 3'd1) >> 1)] <= 33'(prod_r);
            else          crs_r[2'((cnt_r - 3'd1) >> 1)] <=
                            crs_r[2'((cnt_r - 3'd1) >> 1)] - 33'(prod_r);
          end
        end
        ST_ACC_WR: cnt_r <= cnt_r + 3'd1;
        ST_RD_NORM: begin
          if (norm_done) res_r <= norm_res;
        end
        default: ;
      endcase

      if (state_r == ST_OUT && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
        out_res_r   <= res_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  vna_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (norm_start),
    .vec   (norm_vec),
    .done  (norm_done),
    .res   (norm_res)
  );

  assign out_ch.valid          = out_valid_r;
  assign out_ch.normal_x       = out_res_r.x;
  assign out_ch.normal_y       = out_res_r.y;
  assign out_ch.normal_z       = out_res_r.z;
  assign out_ch.normal_defined = out_res_r.defined;

  a_acc_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(acc_we && acc_re))
    else $error("accumulator read and write in the same cycle");

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_ch.ready)
    else $error("command taken during accumulator sweep");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result loaded outside the output state");

endmodule

// ----- bench/vna_checker.sv -----
// ----------------------------------------------------------------------------
// vna_checker
// Watches the command and result channels of the vertex normal accumulator,
// keeps its own copy of the vertex and normal stores, predicts each read
// result and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module vna_checker
  import vna_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  vna_in_if    in_ch,
  vna_out_if   out_ch,
  output int   errors,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NVERT = 1024;
  localparam longint ACC_HI = 64'sd8388607;
  localparam longint ACC_LO = -64'sd8388608;

  longint vtx [NVERT][3];
  longint acc [NVERT][3];
  unit_t  normal_q[$];

  initial begin
    errors = 0;
    for (int i = 0; i < NVERT; i++) begin
      for (int j = 0; j < 3; j++) begin
        vtx[i][j] = 0;
        acc[i][j] = 0;
      end
    end
  end

  assign pending = normal_q.size();

  function automatic longint unsigned isqrt(input longint unsigned x);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x   = x - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // unit length in Q1.14; returns 0 for the zero vector
  function automatic bit to_unit(input longint v [3], output longint u [3]);
    longint unsigned mag [3];
    longint unsigned len2, r, q;
    int k;
    len2 = 0;
    k    = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (v[i] < 0) ? -v[i] : v[i];
      len2   = len2 + mag[i] * mag[i];
      u[i]   = 0;
    end
    if (len2 == 0) return 0;
    while (len2 < (64'd1 << 60)) begin
      len2 = len2 << 2;
      k    = k + 2;
    end
    r = isqrt(len2);
    for (int i = 0; i < 3; i++) begin
      q    = ((mag[i] << (14 + k / 2)) + r / 2) / r;
      u[i] = (v[i] < 0) ? -longint'(q) : longint'(q);
    end
    return 1;
  endfunction

  function automatic longint round_q14(input longint v);
    if (v >= 0) return (v + 8192) >>> 14;
    return -((-v + 8191) >>> 14);
  endfunction

  function automatic void add_face(input int a, input int b, input int c);
    longint e1 [3], e2 [3], u1 [3], u2 [3], n [3], s;
    int corner [3];
    for (int i = 0; i < 3; i++) begin
      e1[i] = vtx[b][i] - vtx[a][i];
      e2[i] = vtx[c][i] - vtx[a][i];
    end
    if (!to_unit(e1, u1) || !to_unit(e2, u2)) return;
    n[0] = round_q14(u1[1] * u2[2] - u1[2] * u2[1]);
    n[1] = round_q14(u1[2] * u2[0] - u1[0] * u2[2]);
    n[2] = round_q14(u1[0] * u2[1] - u1[1] * u2[0]);
    corner = '{a, b, c};
    for (int j = 0; j < 3; j++) begin
      for (int i = 0; i < 3; i++) begin
        s = acc[corner[j]][i] + n[i];
        if (s > ACC_HI) s = ACC_HI;
        if (s < ACC_LO) s = ACC_LO;
        acc[corner[j]][i] = s;
      end
    end
  endfunction

  function automatic unit_t read_normal(input int a);
    longint v [3], u [3];
    unit_t res;
    for (int i = 0; i < 3; i++) v[i] = acc[a][i];
    res.defined = to_unit(v, u);
    res.x = q14_t'(u[0]);
    res.y = q14_t'(u[1]);
    res.z = q14_t'(u[2]);
    return res;
  endfunction

  always @(posedge clk) begin
    unit_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        case (op_t'(in_ch.operation))
          OP_CLEAR: begin
            for (int i = 0; i < NVERT; i++)
              for (int j = 0; j < 3; j++) acc[i][j] = 0;
          end
          OP_WRITE: begin
            vtx[in_ch.vertex_a][0] = in_ch.coord_x;
            vtx[in_ch.vertex_a][1] = in_ch.coord_y;
            vtx[in_ch.vertex_a][2] = in_ch.coord_z;
          end
          OP_FACE: add_face(in_ch.vertex_a, in_ch.vertex_b, in_ch.vertex_c);
          OP_READ: normal_q.push_back(read_normal(in_ch.vertex_a));
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        if (normal_q.size() == 0) begin
          $error("unexpected result transfer");
          errors = errors + 1;
        end else begin
          want = normal_q.pop_front();
          if (out_ch.normal_x !== want.x) begin
            $error("normal_x: expected %0d, got %0d", want.x, out_ch.normal_x);
            errors = errors + 1;
          end
          if (out_ch.normal_y !== want.y) begin
            $error("normal_y: expected %0d, got %0d", want.y, out_ch.normal_y);
            errors = errors + 1;
          end
          if (out_ch.normal_z !== want.z) begin
            $error("normal_z: expected %0d, got %0d", want.z, out_ch.normal_z);
            errors = errors + 1;
          end
          if (out_ch.normal_defined !== want.defined) begin
            $error("normal_defined: expected %0d, got %0d", want.defined,
                   out_ch.normal_defined);
            errors = errors + 1;
          end
        end
      end
    end
  end

endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives vertex writes, faces, reads and clears into the vertex normal
// accumulator with random gaps and result stalls; the checker beside the
// block predicts and compares every read result.
// ----------------------------------------------------------------------------
module tb;
  import vna_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 20000;
  localparam int RAND_ITEMS  = 1650;

  logic clk;
  logic rst_n;
  int   errors;
  int   pending;
  int   quiet;
  bit   busy_mode;
  int   known[$];
  bit   is_known[1024];

  vna_in_if  in_ch ();
  vna_out_if out_ch ();

  vertex_normal_accumulator_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  vna_checker chk (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .errors  (errors),
    .pending (pending)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int draw_gap();
    if (busy_mode) return 0;
    return $urandom_range(0, 14);
  endfunction

  // one command transfer; valid stays high into the next item when no gap
  task automatic issue(input op_t op, input int a, input int b, input int c,
                       input int x, input int y, input int z);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.vertex_a  <= vidx_t'(a);
    in_ch.vertex_b  <= vidx_t'(b);
    in_ch.vertex_c  <= vidx_t'(c);
    in_ch.coord_x   <= coord_t'(x);
    in_ch.coord_y   <= coord_t'(y);
    in_ch.coord_z   <= coord_t'(z);
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op == OP_WRITE && !is_known[a]) begin
      is_known[a] = 1'b1;
      known.push_back(a);
    end
  endtask

  function automatic int rand_coord();
    if ($urandom_range(0, 1)) return $urandom_range(0, 32'hFFFFFF) - 32'sd8388608;
    return $urandom_range(0, 32767) - 16384;
  endfunction

  function automatic int pick_corner();
    if ($urandom_range(0, 9) < 7) return known[$urandom_range(0, 11)];
    return known[$urandom_range(0, known.size() - 1)];
  endfunction

  task automatic random_item();
    int sel, a, b, c;
    sel = $urandom_range(0, 99);
    if (sel < 3) begin
      issue(OP_CLEAR, $urandom_range(0, 1023), $urandom_range(0, 1023),
            $urandom_range(0, 1023), rand_coord(), rand_coord(), rand_coord());
    end else if (sel < 33) begin
      a = ($urandom_range(0, 1)) ? $urandom_range(0, 15) : $urandom_range(0, 1023);
      issue(OP_WRITE, a, $urandom_range(0, 1023), $urandom_range(0, 1023),
            rand_coord(), rand_coord(), rand_coord());
    end else if (sel < 73) begin
      a = pick_corner();
      b = ($urandom_range(0, 9) == 0) ? a : pick_corner();
      c = ($urandom_range(0, 9) == 0) ? a : pick_corner();
      issue(OP_FACE, a, b, c, rand_coord(), rand_coord(), rand_coord());
    end else begin
      a = ($urandom_range(0, 3) != 0) ? pick_corner() : $urandom_range(0, 1023);
      issue(OP_READ, a, $urandom_range(0, 1023), $urandom_range(0, 1023),
            rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  // result side stalls
  initial begin
    int wait_cycles;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      wait_cycles = draw_gap();
      if (wait_cycles > 0) begin
        out_ch.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    quiet           = 0;
    busy_mode       = 1'b0;
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.operation <= OP_CLEAR;
    in_ch.vertex_a  <= '0;
    in_ch.vertex_b  <= '0;
    in_ch.vertex_c  <= '0;
    in_ch.coord_x   <= '0;
    in_ch.coord_y   <= '0;
    in_ch.coord_z   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, degenerate faces, unused vertex, clear
    issue(OP_READ, 5, 0, 0, 0, 0, 0);
    issue(OP_WRITE, 0, 0, 0, 0, 0, 0);
    issue(OP_WRITE, 1, 0, 0, 8388607, 0, 0);
    issue(OP_WRITE, 2, 0, 0, 0, 8388607, 0);
    issue(OP_WRITE, 3, 1023, 1023, -8388608, -8388608, -8388608);
    issue(OP_WRITE, 1023, 0, 0, 8388607, 8388607, 8388607);
    issue(OP_WRITE, 4, 0, 0, 4096, 0, 0);
    issue(OP_WRITE, 5, 0, 0, 1, 0, 0);
    issue(OP_FACE, 0, 1, 2, 0, 0, 0);
    issue(OP_FACE, 0, 0, 2, 0, 0, 0);
    issue(OP_FACE, 0, 1, 0, 0, 0, 0);
    issue(OP_FACE, 0, 1, 4, 0, 0, 0);
    issue(OP_READ, 0, 0, 0, 0, 0, 0);
    issue(OP_READ, 4, 0, 0, 0, 0, 0);
    issue(OP_FACE, 3, 1023, 2, 0, 0, 0);
    issue(OP_FACE, 1023, 3, 1, 0, 0, 0);
    issue(OP_READ, 3, 0, 0, 0, 0, 0);
    issue(OP_READ, 1023, 0, 0, 0, 0, 0);
    issue(OP_CLEAR, 1023, 1023, 1023, -1, -1, -1);
    issue(OP_READ, 0, 0, 0, 0, 0, 0);
    issue(OP_FACE, 0, 5, 2, 0, 0, 0);
    issue(OP_READ, 0, 0, 0, 0, 0, 0);
    issue(OP_READ, 2, 0, 0, 0, 0, 0);
    for (int i = 6; i < 12; i++)
      issue(OP_WRITE, i, 0, 0, rand_coord(), rand_coord(), rand_coord());

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i % 100 == 0) busy_mode = ($urandom_range(0, 3) == 0);
      if (i == 400) begin
        // same face over and over drives the corners into saturation
        for (int j = 0; j < 560; j++) issue(OP_FACE, 0, 1, 2, 0, 0, 0);
        issue(OP_READ, 0, 0, 0, 0, 0, 0);
        issue(OP_READ, 1, 0, 0, 0, 0, 0);
        issue(OP_READ, 2, 0, 0, 0, 0, 0);
        i = i + 563;
      end else begin
        random_item();
      end
    end
    in_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
